// ===== design/dsat_pkg.sv =====
// ----------------------------------------------------------------------------
// dsat_pkg
// Shared constants and types for the graph coloring unit.
// ----------------------------------------------------------------------------
package dsat_pkg;
    localparam int NODES_MAX = 64;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int COL_W     = 6;

    typedef enum logic [1:0] {
        ACT_EDGE  = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;
endpackage

// ===== design/dsatur_graph_coloring_unit.sv =====
// ----------------------------------------------------------------------------
// dsatur_graph_coloring_unit
// Greedy coloring in order of colored-neighbor count over an adjacency row memory.
// ----------------------------------------------------------------------------
// Edge request: accept, then update row a and row b. Clear: accept, then sweep all
// NODES rows. Run, n = active node count: a degree scan over n rows, then for each
// further node an n-row scan, a row read, a read and check of each neighbor color
// and a color write; then the results, each held until taken. Reset: synchronous,
// clears control, node count 64, then a sweep of NODES rows clears the row memory
// (no input taken).
module dsatur_graph_coloring_unit
    import dsat_pkg::*;
#(
    parameter int NODES = NODES_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[1:0], node_a[7:2], node_b[13:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // node_index[5:0], node_color[11:6], top_color[17:12]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data     // node_count[6:0]
);
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_EDGEB = 11'b00000000100,
        S_DEG   = 11'b00000001000,
        S_SEL   = 11'b00000010000,
        S_NBR   = 11'b00000100000,
        S_NBRC  = 11'b00001000000,
        S_PICK  = 11'b00010000000,
        S_OUT   = 11'b00100000000,
        S_OUTW  = 11'b01000000000,
        S_ROWR  = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0] r_ptr, n_ptr, r_j, n_j;
    logic [AW-1:0] r_pick, n_pick, r_best, n_best;
    logic [CNT_W-1:0] r_bsc, n_bsc;
    logic r_have, n_have;
    logic [NODES-1:0] r_cmask, n_cmask, r_row, n_row;
    logic [63:0] r_used, n_used;
    logic [CNT_W-1:0] r_step, n_step;
    logic [COL_W-1:0] r_maxc, n_maxc;
    logic [AW-1:0] r_ea, n_ea, r_eb, n_eb;
    logic r_ov, n_ov;
    logic [23:0] r_od, n_od;
    logic r_ol, n_ol;

    // row memory
    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] r_rd;
    logic [AW-1:0] ra, wa;
    logic we;
    logic [NODES-1:0] wd;
    // color memory
    logic [COL_W-1:0] cmem [NODES];
    logic [COL_W-1:0] r_crd;
    logic [AW-1:0] ca, cwa;
    logic cwe;
    logic [COL_W-1:0] cwd;

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[ra];
        if (cwe) cmem[cwa] <= cwd;
        r_crd <= cmem[ca];
    end

    logic [CNT_W-1:0] n_act;
    logic [NODES-1:0] amask;
    always_comb begin
        if (r_cnt == '0) n_act = CNT_W'(1);
        else if (r_cnt > CNT_W'(NODES)) n_act = CNT_W'(NODES);
        else n_act = r_cnt;
        for (int k = 0; k < NODES; k++) amask[k] = (CNT_W'(k) < n_act);
    end

    logic [CNT_W-1:0] pc;
    logic [NODES-1:0] pv;
    assign pv = r_rd & amask & ((r_st == S_DEG) ? {NODES{1'b1}} : r_cmask);
    always_comb begin
        pc = '0;
        for (int k = 0; k < NODES; k++) pc = pc + CNT_W'(pv[k]);
    end

    logic [COL_W-1:0] freec;
    always_comb begin
        freec = COL_W'(63);
        for (int c = 62; c >= 0; c--) if (!r_used[c]) freec = COL_W'(c);
    end

    logic [15:0] di;
    assign di = s_axis_tdata;
    logic [CNT_W-1:0] lastp;
    assign lastp = n_act - CNT_W'(1);

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
    assign m_axis_tlast = r_ol;

    always_comb begin
        n_st = r_st; n_ptr = r_ptr; n_j = r_j; n_pick = r_pick; n_best = r_best;
        n_bsc = r_bsc; n_have = r_have; n_cmask = r_cmask; n_row = r_row;
        n_used = r_used; n_step = r_step; n_maxc = r_maxc; n_ea = r_ea; n_eb = r_eb;
        n_ov = r_ov; n_od = r_od; n_ol = r_ol;
        ra = r_ptr; we = 1'b0; wa = r_ptr; wd = '0;
        ca = r_j; cwe = 1'b0; cwa = r_pick; cwd = freec;
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        unique case (r_st)
            S_CLR: begin
                we = 1'b1; wa = r_ptr;
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == AW'(NODES - 1)) begin
                    n_st = S_IDLE; n_ptr = '0;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (t_action'(di[1:0]))
                        ACT_EDGE: begin
                            if (32'(di[7:2]) < NODES && 32'(di[13:8]) < NODES
                                && di[7:2] != di[13:8]) begin
                                n_ea = AW'(di[7:2]); n_eb = AW'(di[13:8]);
                                ra = AW'(di[7:2]); n_st = S_ROWR;
                            end
                        end
                        ACT_RUN: begin
                            n_ptr = '0; ra = '0; n_have = 1'b0; n_cmask = '0;
                            n_st = S_DEG;
                        end
                        ACT_CLEAR: begin
                            n_cmask = '0; n_ptr = '0; n_st = S_CLR;
                        end
                        ACT_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_ROWR: begin
                we = 1'b1; wa = r_ea; wd = r_rd | (NODES'(1) << r_eb);
                ra = r_eb; n_st = S_EDGEB;
            end
            S_EDGEB: begin
                we = 1'b1; wa = r_eb; wd = r_rd | (NODES'(1) << r_ea);
                n_st = S_IDLE;
            end
            S_DEG, S_SEL: begin
                // r_rd holds row r_ptr
                if (!(r_st == S_SEL && r_cmask[r_ptr]) && (!r_have || pc > r_bsc)) begin
                    n_have = 1'b1; n_bsc = pc; n_best = r_ptr;
                end
                if (CNT_W'(r_ptr) == lastp) begin
                    if (r_st == S_DEG) begin
                        n_pick = (!r_have || pc > r_bsc) ? r_ptr : r_best;
                        cwe = 1'b1; cwa = n_pick; cwd = '0;
                        n_cmask = r_cmask | (NODES'(1) << n_pick);
                        n_maxc = '0; n_step = CNT_W'(1);
                        if (n_act == CNT_W'(1)) begin
                            n_st = S_OUT; n_j = '0;
                        end else begin
                            n_st = S_SEL; n_ptr = '0; ra = '0; n_have = 1'b0;
                        end
                    end else begin
                        n_pick = n_best; ra = n_best; n_st = S_PICK;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1); ra = n_ptr;
                end
            end
            S_PICK: begin
                n_row = r_rd & r_cmask & amask; n_used = '0; n_j = '0; ca = '0;
                n_st = S_NBR;
            end
            S_NBR: begin
                // r_crd holds color of r_j (read last cycle)
                n_st = S_NBRC;
            end
            S_NBRC: begin
                if (r_row[r_j]) n_used = r_used | (64'(1) << r_crd);
                if (CNT_W'(r_j) == lastp) begin
                    n_st = S_OUTW;
                end else begin
                    n_j = r_j + AW'(1); ca = n_j; n_st = S_NBR;
                end
            end
            S_OUTW: begin
                cwe = 1'b1; cwa = r_pick; cwd = freec;
                if (freec > r_maxc) n_maxc = freec;
                n_cmask = r_cmask | (NODES'(1) << r_pick);
                n_step = r_step + CNT_W'(1);
                if (r_step + CNT_W'(1) == n_act) begin
                    n_st = S_OUT; n_j = '0;
                end else begin
                    n_st = S_SEL; n_ptr = '0; ra = '0; n_have = 1'b0;
                end
            end
            S_OUT: begin
                ca = r_j;
                if (r_have == 1'b0 && !n_ov) begin
                    n_ov = 1'b1;
                    n_od = {6'd0, r_maxc, r_crd, 6'(r_j)};
                    n_ol = (CNT_W'(r_j) == lastp);
                    if (CNT_W'(r_j) == lastp) n_st = S_IDLE;
                    else begin
                        n_j = r_j + AW'(1); ca = n_j;
                    end
                    n_have = 1'b1;
                end else if (r_have) begin
                    n_have = 1'b0;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_ptr <= '0; r_cnt <= CNT_W'(64); r_ov <= 1'b0;
            r_have <= 1'b0; r_cmask <= '0;
        end else begin
            r_st <= n_st; r_ptr <= n_ptr; r_ov <= n_ov; r_have <= n_have;
            r_cmask <= n_cmask;
            if (i_cfg_valid && o_cfg_ready) r_cnt <= i_cfg_data[CNT_W-1:0];
        end
        r_j <= n_j; r_pick <= n_pick; r_best <= n_best; r_bsc <= n_bsc;
        r_row <= n_row; r_used <= n_used; r_step <= n_step; r_maxc <= n_maxc;
        r_ea <= n_ea; r_eb <= n_eb; r_od <= n_od; r_ol <= n_ol;
    end
endmodule
